// ----- rtl/core/equirect_to_cubemap_address_defines.svh -----
// ---------------------------------------------------------------------------
// Equirectangular to cubemap address: assertion macros
// Concurrent check wrappers that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef EQUIRECT_TO_CUBEMAP_ADDRESS_DEFINES_SVH
`define EQUIRECT_TO_CUBEMAP_ADDRESS_DEFINES_SVH
`ifndef SYNTHESIS
// Consequent checked in the same cycle as the antecedent.
`define E2C_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("e2c: same-cycle check failed");
// Consequent checked in the cycle after the antecedent.
`define E2C_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("e2c: next-cycle check failed");
`else
`define E2C_ASSERT_SAME(label, clk, rst, ante, cons)
`define E2C_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/core/e2c_pkg.sv -----
// ---------------------------------------------------------------------------
// Equirectangular to cubemap address: package
// Widths, register codes, pipeline payload types and the arithmetic steps
// shared by the address pipeline.
// ---------------------------------------------------------------------------
package e2c_pkg;

   localparam int ANGLE_BITS   = 18;
   localparam int CORDIC_STEPS = 16;

   localparam int FACE_W = 3;
   localparam int PIX_W  = 12;
   localparam int FS_W   = 13;
   localparam int MW_W   = 14;
   localparam int MH_W   = 13;
   localparam int SX_W   = 13;
   localparam int SY_W   = 12;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 14;

   localparam logic [CSR_IDX_W-1:0] CSR_FACE_SIZE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_HEIGHT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIRROR     = 2'd3;

   localparam logic [FACE_W-1:0] FACE_XP = 3'd0;
   localparam logic [FACE_W-1:0] FACE_XN = 3'd1;
   localparam logic [FACE_W-1:0] FACE_YP = 3'd2;
   localparam logic [FACE_W-1:0] FACE_YN = 3'd3;
   localparam logic [FACE_W-1:0] FACE_ZP = 3'd4;
   localparam logic [FACE_W-1:0] FACE_ZN = 3'd5;

   // Clamped register limits and reset values (map sizes stored minus one).
   localparam logic [FS_W-1:0]   FS_MAX     = 13'd4096;
   localparam logic [FS_W-1:0]   FS_RESET   = 13'd512;
   localparam logic [MW_W-1:0]   MW_MAX     = 14'd8192;
   localparam logic [SX_W-1:0]   MWM1_MAX   = 13'd8191;
   localparam logic [SX_W-1:0]   MWM1_RESET = 13'd4095;
   localparam logic [MH_W-1:0]   MH_MAX     = 13'd4096;
   localparam logic [SY_W-1:0]   MHM1_MAX   = 12'd4095;
   localparam logic [SY_W-1:0]   MHM1_RESET = 12'd2047;

   // Face coordinate division.
   localparam int Q_W            = 18;
   localparam int DIV_PER_STAGE  = 3;
   localparam int DIV_STAGES     = Q_W / DIV_PER_STAGE;
   localparam int COORD_W        = 18;
   localparam logic [Q_W-1:0] Q_SAT = 18'd196607;
   localparam logic signed [COORD_W-1:0] COORD_MAX = 18'sd131071;
   localparam logic signed [COORD_W-1:0] Q16_ONE   = 18'sd65536;

   // Direction vector and CORDIC datapath.
   localparam int DIR_SHIFT        = 6;
   localparam int DIR_W            = COORD_W + DIR_SHIFT;
   localparam int CW               = 28;
   localparam int ANG_W            = 32;
   localparam int CORDIC_PER_STAGE = 2;
   localparam int CORDIC_STAGES    = CORDIC_STEPS / CORDIC_PER_STAGE;
   localparam int GAIN_SHIFT       = 16;
   localparam logic signed [COORD_W-1:0] GAIN_Q16 = 18'sd107922;
   localparam logic [ANG_W-1:0] HALF_TURN  = 32'h8000_0000;
   localparam logic [ANG_W-1:0] THETA_WRAP = 32'hC000_0000;

   localparam logic [ANG_W-1:0] ATAN_TURN [24] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
      32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
   };

   typedef struct packed {
      logic [FS_W-1:0] r;
      logic [Q_W-1:0]  q;
   } divq_type;

   typedef struct packed {
      logic [FACE_W-1:0] face;
      logic              sat_x;
      logic              sat_y;
      logic              lsb_x;
      logic              lsb_y;
      divq_type          qx;
      divq_type          qy;
   } div_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic [ANG_W-1:0]     z;
   } cordic_type;

   typedef struct packed {
      cordic_type              c;
      logic signed [DIR_W-1:0] dz;
   } c1_type;

   typedef struct packed {
      logic signed [CW-1:0]  dzk;
      logic signed [CW-1:0]  rho;
      logic [ANGLE_BITS:0]   sp;
   } mul_type;

   typedef struct packed {
      cordic_type          c;
      logic [ANGLE_BITS:0] sp;
   } c2_type;

   typedef struct packed {
      logic [SX_W-1:0] source_x;
      logic [SY_W-1:0] source_y;
   } out_type;

   // One restoring division step: shift in one dividend bit, subtract if it fits.
   function automatic divq_type div_step(divq_type d, logic b, logic [FS_W-1:0] fs);
      logic [FS_W:0] r2;
      divq_type      o;
      r2 = {d.r, b};
      o.q = {d.q[Q_W-2:0], 1'b0};
      if (r2 >= {1'b0, fs}) begin
         r2 = r2 - {1'b0, fs};
         o.q[0] = 1'b1;
      end
      o.r = r2[FS_W-1:0];
      return o;
   endfunction

   // Quotient to signed Q2.16 coordinate, saturated at the top.
   function automatic logic signed [COORD_W-1:0] face_coord(logic sat, logic [Q_W-1:0] q);
      logic [COORD_W:0] c;
      c = {1'b0, q} - {1'b0, Q16_ONE};
      if (sat || (q > Q_SAT)) begin
         return COORD_MAX;
      end
      return c[COORD_W-1:0];
   endfunction

   // One vectoring CORDIC micro-rotation driving y toward zero.
   function automatic cordic_type cordic_step(cordic_type c, int i);
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] xs;
      logic signed [CW-1:0] ys;
      cordic_type           o;
      x  = c.x;
      y  = c.y;
      xs = x >>> i;
      ys = y >>> i;
      if (!y[CW-1]) begin
         o.x = x + ys;
         o.y = y - xs;
         o.z = c.z + ATAN_TURN[i];
      end else begin
         o.x = x - ys;
         o.y = y + xs;
         o.z = c.z - ATAN_TURN[i];
      end
      return o;
   endfunction

endpackage

// ----- rtl/core/e2c_if.sv -----
// ---------------------------------------------------------------------------
// Equirectangular to cubemap address: channel interfaces
// Valid/ready channels for pixel requests, address responses and register
// writes.
// ---------------------------------------------------------------------------
interface e2c_req_if;
   logic                       valid;
   logic                       ready;
   logic [e2c_pkg::FACE_W-1:0] face;
   logic [e2c_pkg::PIX_W-1:0]  pixel_x;
   logic [e2c_pkg::PIX_W-1:0]  pixel_y;

   modport source (output valid, face, pixel_x, pixel_y, input ready);
   modport sink   (input valid, face, pixel_x, pixel_y, output ready);
endinterface

interface e2c_rsp_if;
   logic                     valid;
   logic                     ready;
   logic [e2c_pkg::SX_W-1:0] source_x;
   logic [e2c_pkg::SY_W-1:0] source_y;

   modport source (output valid, source_x, source_y, input ready);
   modport sink   (input valid, source_x, source_y, output ready);
endinterface

interface e2c_csr_if;
   logic                           valid;
   logic                           ready;
   logic [e2c_pkg::CSR_IDX_W-1:0]  index;
   logic [e2c_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/equirect_to_cubemap_address.sv -----
// ---------------------------------------------------------------------------
// Equirectangular to cubemap address generator
// Maps a cube-face pixel to the equirectangular pixel it samples from.
// ---------------------------------------------------------------------------
// Usage:
// A request on req_chan carries a face code and a pixel column and row. The
// response on rsp_chan carries the source column and row in the map. The
// csr_chan port writes face_size, map_width, map_height and
// mirror_horizontal; it is always ready and should be written only while no
// request is in flight.
// The datapath is a 26-stage pipeline: six stages of restoring division for
// the face coordinates, a direction stage, eight stages of azimuth CORDIC at
// two micro-rotations each, a gain multiply stage, a pre-rotation stage,
// eight stages of polar CORDIC and a scaling multiply stage. A new request
// is taken every cycle while the skid register is empty.
// When rsp_chan stalls, the stalled response moves into a skid register and
// the pipe freezes once the skid is full, so req_chan.ready is a register.
// Reset empties the pipe and the skid and loads the register reset values;
// it takes effect at the next rising clock edge.
// ---------------------------------------------------------------------------
`include "equirect_to_cubemap_address_defines.svh"

module equirect_to_cubemap_address (
   input logic       clock,
   input logic       reset,
   e2c_req_if.sink   req_chan,
   e2c_rsp_if.source rsp_chan,
   e2c_csr_if.sink   csr_chan
);

   localparam int NST = e2c_pkg::DIV_STAGES + 2 * (e2c_pkg::CORDIC_STAGES + 1) + 2;
   localparam int DL  = e2c_pkg::DIV_STAGES - 1;
   localparam int CL  = e2c_pkg::CORDIC_STAGES;

   // Configuration, stored already clamped.
   logic [e2c_pkg::FS_W-1:0] fs_ff;
   logic [e2c_pkg::SX_W-1:0] mwm1_ff;
   logic [e2c_pkg::SY_W-1:0] mhm1_ff;
   logic                     mirror_ff;
   logic [e2c_pkg::FS_W-1:0] fs_wr;
   logic [e2c_pkg::SX_W-1:0] mwm1_wr;
   logic [e2c_pkg::SY_W-1:0] mhm1_wr;
   logic                     csr_acc;

   // Handshake and pipeline control.
   logic           in_acc;
   logic           out_acc;
   logic           pipe_en;
   logic [NST-1:0] vld_ff;
   logic [NST-1:0] vld_in;
   logic           skid_vld_ff;
   logic           skid_vld_in;
   e2c_pkg::out_type skid_ff;

   // Pipeline payload.
   e2c_pkg::div_type div_init;
   e2c_pkg::div_type div_src [e2c_pkg::DIV_STAGES];
   e2c_pkg::div_type div_in  [e2c_pkg::DIV_STAGES];
   e2c_pkg::div_type div_ff  [e2c_pkg::DIV_STAGES];
   e2c_pkg::c1_type  c1_in   [CL+1];
   e2c_pkg::c1_type  c1_ff   [CL+1];
   e2c_pkg::mul_type mul_in;
   e2c_pkg::mul_type mul_ff;
   e2c_pkg::c2_type  c2_in   [CL+1];
   e2c_pkg::c2_type  c2_ff   [CL+1];
   e2c_pkg::out_type out_in;
   e2c_pkg::out_type out_ff;

   // ------------------------------------------------------------------------
   // Register port
   // ------------------------------------------------------------------------
   assign csr_chan.ready = 1'b1;
   assign csr_acc        = csr_chan.valid & csr_chan.ready;

   always_comb begin
      logic [e2c_pkg::FS_W-1:0] d_fs;
      logic [e2c_pkg::MW_W-1:0] d_mw;
      logic [e2c_pkg::MH_W-1:0] d_mh;
      logic [e2c_pkg::MW_W-1:0] mw_m1;
      logic [e2c_pkg::MH_W-1:0] mh_m1;
      d_fs  = csr_chan.data[e2c_pkg::FS_W-1:0];
      d_mw  = csr_chan.data[e2c_pkg::MW_W-1:0];
      d_mh  = csr_chan.data[e2c_pkg::MH_W-1:0];
      mw_m1 = d_mw - 1'b1;
      mh_m1 = d_mh - 1'b1;
      if (d_fs == '0) begin
         fs_wr = e2c_pkg::FS_W'(1);
      end else if (d_fs > e2c_pkg::FS_MAX) begin
         fs_wr = e2c_pkg::FS_MAX;
      end else begin
         fs_wr = d_fs;
      end
      if (d_mw == '0) begin
         mwm1_wr = '0;
      end else if (d_mw > e2c_pkg::MW_MAX) begin
         mwm1_wr = e2c_pkg::MWM1_MAX;
      end else begin
         mwm1_wr = mw_m1[e2c_pkg::SX_W-1:0];
      end
      if (d_mh == '0) begin
         mhm1_wr = '0;
      end else if (d_mh > e2c_pkg::MH_MAX) begin
         mhm1_wr = e2c_pkg::MHM1_MAX;
      end else begin
         mhm1_wr = mh_m1[e2c_pkg::SY_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fs_ff     <= e2c_pkg::FS_RESET;
         mwm1_ff   <= e2c_pkg::MWM1_RESET;
         mhm1_ff   <= e2c_pkg::MHM1_RESET;
         mirror_ff <= 1'b0;
      end else if (csr_acc) begin
         unique case (csr_chan.index)
            e2c_pkg::CSR_FACE_SIZE:  fs_ff     <= fs_wr;
            e2c_pkg::CSR_MAP_WIDTH:  mwm1_ff   <= mwm1_wr;
            e2c_pkg::CSR_MAP_HEIGHT: mhm1_ff   <= mhm1_wr;
            e2c_pkg::CSR_MIRROR:     mirror_ff <= csr_chan.data[0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Pipeline control: the whole pipe advances unless the skid is holding.
   // ------------------------------------------------------------------------
   assign pipe_en        = ~skid_vld_ff;
   assign req_chan.ready = ~skid_vld_ff;
   assign in_acc         = req_chan.valid & req_chan.ready;
   assign out_acc        = rsp_chan.valid & rsp_chan.ready;
   assign vld_in         = {vld_ff[NST-2:0], in_acc};

   always_comb begin
      skid_vld_in = skid_vld_ff;
      if (skid_vld_ff) begin
         if (rsp_chan.ready) begin
            skid_vld_in = 1'b0;
         end
      end else if (vld_ff[NST-1] && !rsp_chan.ready) begin
         skid_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         skid_vld_ff <= 1'b0;
      end else begin
         skid_vld_ff <= skid_vld_in;
         if (pipe_en) begin
            vld_ff <= vld_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_vld_ff && vld_ff[NST-1] && !rsp_chan.ready) begin
         skid_ff <= out_ff;
      end
   end

   assign rsp_chan.valid    = skid_vld_ff | vld_ff[NST-1];
   assign rsp_chan.source_x = skid_vld_ff ? skid_ff.source_x : out_ff.source_x;
   assign rsp_chan.source_y = skid_vld_ff ? skid_ff.source_y : out_ff.source_y;

   // ------------------------------------------------------------------------
   // Face coordinates: 2^17 * pixel / face_size by restoring division. The
   // initial remainder is pixel/2; a pixel at or beyond twice the face size
   // would need more quotient bits and saturates instead.
   // ------------------------------------------------------------------------
   always_comb begin
      div_init.face  = req_chan.face;
      div_init.sat_x = {2'b00, req_chan.pixel_x} >= {fs_ff, 1'b0};
      div_init.sat_y = {2'b00, req_chan.pixel_y} >= {fs_ff, 1'b0};
      div_init.lsb_x = req_chan.pixel_x[0];
      div_init.lsb_y = req_chan.pixel_y[0];
      div_init.qx.r  = {2'b00, req_chan.pixel_x[e2c_pkg::PIX_W-1:1]};
      div_init.qx.q  = '0;
      div_init.qy.r  = {2'b00, req_chan.pixel_y[e2c_pkg::PIX_W-1:1]};
      div_init.qy.q  = '0;
   end

   for (genvar gs = 0; gs < e2c_pkg::DIV_STAGES; gs++) begin : g_div
      if (gs == 0) begin : g_first
         assign div_src[gs] = div_init;
      end else begin : g_rest
         assign div_src[gs] = div_ff[gs-1];
      end

      always_comb begin
         e2c_pkg::div_type d;
         d = div_src[gs];
         for (int j = 0; j < e2c_pkg::DIV_PER_STAGE; j++) begin
            d.qx = e2c_pkg::div_step(d.qx,
                                     (gs * e2c_pkg::DIV_PER_STAGE + j == 0) ? d.lsb_x : 1'b0,
                                     fs_ff);
            d.qy = e2c_pkg::div_step(d.qy,
                                     (gs * e2c_pkg::DIV_PER_STAGE + j == 0) ? d.lsb_y : 1'b0,
                                     fs_ff);
         end
         div_in[gs] = d;
      end

      always_ff @(posedge clock) begin
         if (pipe_en) begin
            div_ff[gs] <= div_in[gs];
         end
      end
   end

   // ------------------------------------------------------------------------
   // Direction vector for the face, scaled by 64, folded into the right
   // half-plane for the azimuth CORDIC.
   // ------------------------------------------------------------------------
   always_comb begin
      logic signed [e2c_pkg::COORD_W-1:0] u;
      logic signed [e2c_pkg::COORD_W-1:0] v;
      logic signed [e2c_pkg::COORD_W-1:0] dx;
      logic signed [e2c_pkg::COORD_W-1:0] dy;
      logic signed [e2c_pkg::COORD_W-1:0] dz;
      logic signed [e2c_pkg::CW-1:0]      x;
      logic signed [e2c_pkg::CW-1:0]      y;
      u = e2c_pkg::face_coord(div_ff[DL].sat_x, div_ff[DL].qx.q);
      v = e2c_pkg::face_coord(div_ff[DL].sat_y, div_ff[DL].qy.q);
      unique case (div_ff[DL].face)
         e2c_pkg::FACE_XN: begin
            dx = u;  dy = -e2c_pkg::Q16_ONE; dz = -v;
         end
         e2c_pkg::FACE_YP: begin
            dx = v;  dy = u;  dz = e2c_pkg::Q16_ONE;
         end
         e2c_pkg::FACE_YN: begin
            dx = -v; dy = u;  dz = -e2c_pkg::Q16_ONE;
         end
         e2c_pkg::FACE_ZP: begin
            dx = e2c_pkg::Q16_ONE;  dy = u;  dz = -v;
         end
         e2c_pkg::FACE_ZN: begin
            dx = -e2c_pkg::Q16_ONE; dy = -u; dz = -v;
         end
         default: begin
            // The x+ face and the unused codes.
            dx = -u; dy = e2c_pkg::Q16_ONE; dz = -v;
         end
      endcase
      x = e2c_pkg::CW'(dx) <<< e2c_pkg::DIR_SHIFT;
      y = e2c_pkg::CW'(dy) <<< e2c_pkg::DIR_SHIFT;
      c1_in[0].c.z = '0;
      if (x < 0) begin
         x = -x;
         y = -y;
         c1_in[0].c.z = e2c_pkg::HALF_TURN;
      end
      c1_in[0].c.x = x;
      c1_in[0].c.y = y;
      c1_in[0].dz  = e2c_pkg::DIR_W'(dz) <<< e2c_pkg::DIR_SHIFT;
   end

   // ------------------------------------------------------------------------
   // Azimuth CORDIC.
   // ------------------------------------------------------------------------
   for (genvar gc = 1; gc <= CL; gc++) begin : g_c1
      always_comb begin
         e2c_pkg::c1_type d;
         d = c1_ff[gc-1];
         for (int j = 0; j < e2c_pkg::CORDIC_PER_STAGE; j++) begin
            d.c = e2c_pkg::cordic_step(d.c, (gc - 1) * e2c_pkg::CORDIC_PER_STAGE + j);
         end
         c1_in[gc] = d;
      end
   end

   for (genvar gr = 0; gr <= CL; gr++) begin : g_c1_reg
      always_ff @(posedge clock) begin
         if (pipe_en) begin
            c1_ff[gr] <= c1_in[gr];
         end
      end
   end

   // ------------------------------------------------------------------------
   // Gain compensation of dz and the horizontal fraction of a turn.
   // ------------------------------------------------------------------------
   always_comb begin
      logic signed [e2c_pkg::DIR_W+e2c_pkg::COORD_W-1:0] prod;
      logic [e2c_pkg::ANGLE_BITS-1:0]                    s;
      logic [e2c_pkg::ANG_W-1:0]                         phi;
      phi  = c1_ff[CL].c.z;
      prod = c1_ff[CL].dz * e2c_pkg::GAIN_Q16;
      mul_in.dzk = e2c_pkg::CW'(prod >>> e2c_pkg::GAIN_SHIFT);
      mul_in.rho = c1_ff[CL].c.x;
      // Adding a half turn flips the top bit of the angle.
      s = {~phi[e2c_pkg::ANG_W-1],
           phi[e2c_pkg::ANG_W-2:e2c_pkg::ANG_W-e2c_pkg::ANGLE_BITS]};
      if (mirror_ff) begin
         mul_in.sp = {1'b1, {e2c_pkg::ANGLE_BITS{1'b0}}} - {1'b0, s};
      end else begin
         mul_in.sp = {1'b0, s};
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         mul_ff <= mul_in;
      end
   end

   // ------------------------------------------------------------------------
   // Polar CORDIC on (dz * gain, rho).
   // ------------------------------------------------------------------------
   always_comb begin
      c2_in[0].sp = mul_ff.sp;
      if (mul_ff.dzk < 0) begin
         c2_in[0].c.x = -mul_ff.dzk;
         c2_in[0].c.y = -mul_ff.rho;
         c2_in[0].c.z = e2c_pkg::HALF_TURN;
      end else begin
         c2_in[0].c.x = mul_ff.dzk;
         c2_in[0].c.y = mul_ff.rho;
         c2_in[0].c.z = '0;
      end
   end

   for (genvar gc = 1; gc <= CL; gc++) begin : g_c2
      always_comb begin
         e2c_pkg::c2_type d;
         d = c2_ff[gc-1];
         for (int j = 0; j < e2c_pkg::CORDIC_PER_STAGE; j++) begin
            d.c = e2c_pkg::cordic_step(d.c, (gc - 1) * e2c_pkg::CORDIC_PER_STAGE + j);
         end
         c2_in[gc] = d;
      end
   end

   for (genvar gr = 0; gr <= CL; gr++) begin : g_c2_reg
      always_ff @(posedge clock) begin
         if (pipe_en) begin
            c2_ff[gr] <= c2_in[gr];
         end
      end
   end

   // ------------------------------------------------------------------------
   // Clamp the polar angle to [0, half turn] and scale both fractions.
   // ------------------------------------------------------------------------
   always_comb begin
      logic [e2c_pkg::ANG_W-1:0]                 theta;
      logic [e2c_pkg::ANGLE_BITS:0]              t;
      logic [e2c_pkg::ANGLE_BITS+e2c_pkg::SX_W:0] prodx;
      logic [e2c_pkg::ANGLE_BITS+e2c_pkg::SY_W:0] prody;
      theta = c2_ff[CL].c.z;
      if (theta > e2c_pkg::THETA_WRAP) begin
         theta = '0;
      end else if (theta > e2c_pkg::HALF_TURN) begin
         theta = e2c_pkg::HALF_TURN;
      end
      t     = theta[e2c_pkg::ANG_W-1:e2c_pkg::ANG_W-1-e2c_pkg::ANGLE_BITS];
      prodx = c2_ff[CL].sp * mwm1_ff;
      prody = t * mhm1_ff;
      out_in.source_x = prodx[e2c_pkg::ANGLE_BITS+e2c_pkg::SX_W-1:e2c_pkg::ANGLE_BITS];
      out_in.source_y = prody[e2c_pkg::ANGLE_BITS+e2c_pkg::SY_W-1:e2c_pkg::ANGLE_BITS];
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         out_ff <= out_in;
      end
   end

   // ------------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------------
   // A stalled response with an empty skid must be parked in the skid.
   `E2C_ASSERT_NEXT(a_skid_capture, clock, reset, (vld_ff[NST-1] && !skid_vld_ff && !rsp_chan.ready), skid_vld_ff)
   // Requests in flight change only by acceptances and deliveries.
   `E2C_ASSERT_NEXT(a_occupancy, clock, reset, 1'b1, (($countones(vld_ff) + skid_vld_ff) == ($past($countones(vld_ff)) + $past(skid_vld_ff) + $past(in_acc) - $past(out_acc))))
   // The stored divisor is never zero nor above the largest face.
   `E2C_ASSERT_SAME(a_fs_range, clock, reset, 1'b1, ((fs_ff != '0) && (fs_ff <= e2c_pkg::FS_MAX)))

endmodule
